// File: hw/rtl/integer_to_text_formatter_core_defines.svh
// assertion macros shared by the text formatter rtl
// no dependencies; expects clk_i and rst_ni in the using module
`ifndef INTEGER_TO_TEXT_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_CORE_DEFINES_SVH

`ifndef SYNTH

`define ITF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ITF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ITF_ASSERT_IMPL(lbl, ante, cons, msg)

`define ITF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/itf_pkg.sv
// types, constants and helpers for the integer to text formatter
// used by itf_ctrl, itf_datapath and the top level
`default_nettype none

package itf_pkg;

  localparam int unsigned ValueW     = 64;
  localparam int unsigned MaxChars   = 64;
  localparam int unsigned PrecMax    = MaxChars - 3;
  localparam int unsigned WidthW     = 7;
  localparam int unsigned PrecW      = 6;
  localparam int unsigned CountW     = $clog2(MaxChars + 1);
  localparam int unsigned DigitCount = 22;
  localparam int unsigned DigitIdxW  = $clog2(DigitCount);
  localparam int unsigned LenW       = $clog2(DigitCount + 1);

  localparam logic [1:0] SizeInt   = 2'd0;
  localparam logic [1:0] SizeShort = 2'd1;

  localparam logic [1:0] RadixDec = 2'd0;
  localparam logic [1:0] RadixOct = 2'd1;
  localparam logic [1:0] RadixHex = 2'd2;

  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharX     = 8'h78;

  typedef enum logic [2:0] {
    SegPad   = 3'd0,
    SegSign  = 3'd1,
    SegPfx0  = 3'd2,
    SegPfxX  = 3'd3,
    SegZero  = 3'd4,
    SegDigit = 3'd5
  } seg_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic len_calc;
    logic plan;
    logic emit;
    seg_e seg;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic conv_done;
    logic has_lpad;
    logic has_sign;
    logic has_pfx0;
    logic has_pfxx;
    logic has_zero;
    logic has_tpad;
    logic pcnt_one;
    logic zcnt_one;
    logic didx_zero;
  } sts_t;

  // digit set 0-9 then lower-case letters
  function automatic logic [7:0] digit_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CharZero + {4'b0, nib};
    end else begin
      c = 8'h57 + {4'b0, nib};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/itf_datapath.sv
// datapath of the text formatter: operand load, bcd conversion,
// length and pad planning, character select and output register; uses itf_pkg
`default_nettype none

module itf_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire itf_pkg::cmd_t                 cmd_i,
  output itf_pkg::sts_t                      sts_o,
  input  wire logic [itf_pkg::ValueW-1:0]    value_i,
  input  wire logic [1:0]                    size_mode_i,
  input  wire logic                          is_unsigned_i,
  input  wire logic [1:0]                    radix_select_i,
  input  wire logic                          alt_form_i,
  input  wire logic                          left_justify_i,
  input  wire logic                          zero_pad_i,
  input  wire logic [itf_pkg::WidthW-1:0]    width_i,
  input  wire logic [itf_pkg::PrecW-1:0]     precision_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         char_code_o,
  output logic                               last_char_o
);

  `include "integer_to_text_formatter_core_defines.svh"

  localparam int unsigned Vw = itf_pkg::ValueW;
  localparam int unsigned Nd = itf_pkg::DigitCount;
  localparam int unsigned Cw = itf_pkg::CountW;
  localparam int unsigned Lw = itf_pkg::LenW;
  localparam int unsigned Iw = itf_pkg::DigitIdxW;

  logic            left_q, zpad_q, alt_q, neg_q;
  logic [1:0]      rsel_q;
  logic [itf_pkg::WidthW-1:0] wid_q;
  logic [itf_pkg::PrecW-1:0]  prec_q;
  logic [Vw-1:0]   sh_q, sh_d;
  logic [Cw-1:0]   conv_q, conv_d;
  logic [3:0]      dig_q [Nd];
  logic [3:0]      dig_d [Nd];
  logic [3:0]      adj   [Nd];
  logic [Lw-1:0]   len_q, len_calc;
  logic [Cw-1:0]   pcnt_q, zcnt_q, pcnt_d, zcnt_d;
  logic [Iw-1:0]   didx_q;
  logic            out_valid_q, last_q;
  logic [7:0]      char_q, char_d;

  logic [Vw-1:0]   x_val, mask, neg_val, u_val, aligned;
  logic [Vw+1:0]   u_ext;
  logic            sbit, neg_d;
  logic [Cw-1:0]   bits;
  logic            pfx0, pfxx, out_free;
  logic [Cw-1:0]   prec7, len7, pre7, zer7, total7, pad7;

  // operand cut, sign and magnitude
  always_comb begin
    unique case (size_mode_i)
      itf_pkg::SizeShort: begin
        mask    = {{(Vw-16){1'b0}}, {16{1'b1}}};
        sbit    = value_i[15];
        bits    = Cw'(16);
        aligned = '0;
      end
      itf_pkg::SizeInt: begin
        mask    = {{(Vw-32){1'b0}}, {32{1'b1}}};
        sbit    = value_i[31];
        bits    = Cw'(32);
        aligned = '0;
      end
      default: begin
        mask    = '1;
        sbit    = value_i[Vw-1];
        bits    = Cw'(Vw);
        aligned = '0;
      end
    endcase
    x_val   = value_i & mask;
    neg_d   = !is_unsigned_i && sbit;
    neg_val = (~x_val + {{(Vw-1){1'b0}}, 1'b1}) & mask;
    u_val   = neg_d ? neg_val : x_val;
    u_ext   = {2'b00, u_val};
    unique case (size_mode_i)
      itf_pkg::SizeShort: aligned = u_val << (Vw - 16);
      itf_pkg::SizeInt:   aligned = u_val << (Vw - 32);
      default:            aligned = u_val;
    endcase
  end

  // bcd add-3 correction
  always_comb begin
    for (int i = 0; i < Nd; i++) begin
      adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
    end
  end

  always_comb begin
    sh_d   = sh_q;
    conv_d = conv_q;
    for (int i = 0; i < Nd; i++) begin
      dig_d[i] = dig_q[i];
    end
    if (cmd_i.load) begin
      sh_d = aligned;
      if (radix_select_i == itf_pkg::RadixOct) begin
        conv_d = '0;
        for (int i = 0; i < Nd; i++) begin
          dig_d[i] = {1'b0, u_ext[3*i +: 3]};
        end
      end else if (radix_select_i == itf_pkg::RadixHex) begin
        conv_d = '0;
        for (int i = 0; i < Nd; i++) begin
          dig_d[i] = 4'd0;
        end
        for (int i = 0; i < Vw / 4; i++) begin
          dig_d[i] = u_val[4*i +: 4];
        end
      end else begin
        conv_d = bits;
        for (int i = 0; i < Nd; i++) begin
          dig_d[i] = 4'd0;
        end
      end
    end else if (cmd_i.conv_step) begin
      sh_d     = {sh_q[Vw-2:0], 1'b0};
      conv_d   = conv_q - Cw'(1);
      dig_d[0] = {adj[0][2:0], sh_q[Vw-1]};
      for (int i = 1; i < Nd; i++) begin
        dig_d[i] = {adj[i][2:0], adj[i-1][3]};
      end
    end
  end

  // significant digit count, at least one
  always_comb begin
    len_calc = Lw'(1);
    for (int i = 0; i < Nd; i++) begin
      if (dig_q[i] != 4'd0) begin
        len_calc = Lw'(i + 1);
      end
    end
  end

  assign pfx0 = alt_q && (rsel_q == itf_pkg::RadixOct || rsel_q == itf_pkg::RadixHex);
  assign pfxx = alt_q && (rsel_q == itf_pkg::RadixHex);

  // pad and precision planning
  always_comb begin
    prec7  = Cw'(prec_q);
    len7   = Cw'(len_q);
    pre7   = Cw'(neg_q) + Cw'(pfx0) + Cw'(pfxx);
    zer7   = (prec7 > len7) ? prec7 - len7 : '0;
    total7 = pre7 + zer7 + len7;
    pad7   = (wid_q > total7) ? wid_q - total7 : '0;
    if (pad7 != '0 && zpad_q && !left_q) begin
      zcnt_d = zer7 + pad7;
      pcnt_d = '0;
    end else begin
      zcnt_d = zer7;
      pcnt_d = pad7;
    end
  end

  always_comb begin
    unique case (cmd_i.seg)
      itf_pkg::SegPad:   char_d = zpad_q ? itf_pkg::CharZero : itf_pkg::CharSpace;
      itf_pkg::SegSign:  char_d = itf_pkg::CharMinus;
      itf_pkg::SegPfx0:  char_d = itf_pkg::CharZero;
      itf_pkg::SegPfxX:  char_d = itf_pkg::CharX;
      itf_pkg::SegZero:  char_d = itf_pkg::CharZero;
      itf_pkg::SegDigit: char_d = itf_pkg::digit_char(dig_q[didx_q]);
      default:           char_d = itf_pkg::CharSpace;
    endcase
  end

  // operand and work registers
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    for (int i = 0; i < Nd; i++) begin
      dig_q[i] <= dig_d[i];
    end
    if (cmd_i.load) begin
      left_q <= left_justify_i;
      zpad_q <= zero_pad_i;
      alt_q  <= alt_form_i;
      rsel_q <= radix_select_i;
      neg_q  <= neg_d;
      wid_q  <= (width_i > itf_pkg::WidthW'(itf_pkg::MaxChars)) ?
                itf_pkg::WidthW'(itf_pkg::MaxChars) : width_i;
      prec_q <= (precision_i > itf_pkg::PrecW'(itf_pkg::PrecMax)) ?
                itf_pkg::PrecW'(itf_pkg::PrecMax) : precision_i;
    end
    if (cmd_i.len_calc) begin
      len_q  <= len_calc;
      didx_q <= Iw'(len_calc - Lw'(1));
    end
    if (cmd_i.plan) begin
      pcnt_q <= pcnt_d;
      zcnt_q <= zcnt_d;
    end
    if (cmd_i.emit) begin
      unique case (cmd_i.seg)
        itf_pkg::SegPad:   pcnt_q <= pcnt_q - Cw'(1);
        itf_pkg::SegZero:  zcnt_q <= zcnt_q - Cw'(1);
        itf_pkg::SegDigit: didx_q <= didx_q - Iw'(1);
        default: begin
        end
      endcase
      char_q <= char_d;
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      conv_q <= conv_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.out_free  = out_free;
    sts_o.conv_done = (conv_q == '0);
    sts_o.has_lpad  = !left_q && (pcnt_q != '0);
    sts_o.has_sign  = neg_q;
    sts_o.has_pfx0  = pfx0;
    sts_o.has_pfxx  = pfxx;
    sts_o.has_zero  = (zcnt_q != '0);
    sts_o.has_tpad  = left_q && (pcnt_q != '0);
    sts_o.pcnt_one  = (pcnt_q == Cw'(1));
    sts_o.zcnt_one  = (zcnt_q == Cw'(1));
    sts_o.didx_zero = (didx_q == '0);
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  `ITF_ASSERT_IMPL(a_digit_in_range, cmd_i.emit && cmd_i.seg == itf_pkg::SegDigit,
    Lw'(didx_q) < len_q, "digit index beyond digit count")
  `ITF_ASSERT_IMPL(a_len_nonzero, cmd_i.plan, len_q != '0, "planning with zero length")

endmodule

`default_nettype wire

// File: hw/rtl/itf_ctrl.sv
// controller state machine of the text formatter
// walks load, conversion, planning and the character segments; uses itf_pkg
`default_nettype none

module itf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire itf_pkg::sts_t sts_i,
  output itf_pkg::cmd_t      cmd_o
);

  `include "integer_to_text_formatter_core_defines.svh"

  typedef enum logic [11:0] {
    StIdle  = 12'b0000_0000_0001,
    StConv  = 12'b0000_0000_0010,
    StLen   = 12'b0000_0000_0100,
    StPlan  = 12'b0000_0000_1000,
    StDisp  = 12'b0000_0001_0000,
    StLpad  = 12'b0000_0010_0000,
    StSign  = 12'b0000_0100_0000,
    StPfx0  = 12'b0000_1000_0000,
    StPfxX  = 12'b0001_0000_0000,
    StZero  = 12'b0010_0000_0000,
    StDigit = 12'b0100_0000_0000,
    StTpad  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  function automatic state_e after_pfx(input itf_pkg::sts_t s);
    return s.has_zero ? StZero : StDigit;
  endfunction

  function automatic state_e after_sign(input itf_pkg::sts_t s);
    return s.has_pfx0 ? StPfx0 : after_pfx(s);
  endfunction

  function automatic state_e after_pad(input itf_pkg::sts_t s);
    return s.has_sign ? StSign : after_sign(s);
  endfunction

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.seg     = itf_pkg::SegPad;
    in_stall_o    = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        if (sts_i.conv_done) begin
          state_d = StLen;
        end else begin
          cmd_o.conv_step = 1'b1;
        end
      end
      StLen: begin
        cmd_o.len_calc = 1'b1;
        state_d        = StPlan;
      end
      StPlan: begin
        cmd_o.plan = 1'b1;
        state_d    = StDisp;
      end
      StDisp: begin
        state_d = sts_i.has_lpad ? StLpad : after_pad(sts_i);
      end
      StLpad: begin
        cmd_o.seg = itf_pkg::SegPad;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.pcnt_one) begin
            state_d = after_pad(sts_i);
          end
        end
      end
      StSign: begin
        cmd_o.seg = itf_pkg::SegSign;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = after_sign(sts_i);
        end
      end
      StPfx0: begin
        cmd_o.seg = itf_pkg::SegPfx0;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.has_pfxx ? StPfxX : after_pfx(sts_i);
        end
      end
      StPfxX: begin
        cmd_o.seg = itf_pkg::SegPfxX;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = after_pfx(sts_i);
        end
      end
      StZero: begin
        cmd_o.seg = itf_pkg::SegZero;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.zcnt_one) begin
            state_d = StDigit;
          end
        end
      end
      StDigit: begin
        cmd_o.seg = itf_pkg::SegDigit;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.didx_zero) begin
            cmd_o.last = !sts_i.has_tpad;
            state_d    = sts_i.has_tpad ? StTpad : StIdle;
          end
        end
      end
      StTpad: begin
        cmd_o.seg = itf_pkg::SegPad;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.pcnt_one) begin
            cmd_o.last = 1'b1;
            state_d    = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `ITF_ASSERT_IMPL(a_emit_into_free, cmd_o.emit, sts_i.out_free,
    "character issued while output register is held")
  `ITF_ASSERT_NEXT(a_last_to_idle, cmd_o.emit && cmd_o.last, state_q == StIdle,
    "final character did not return to idle")

endmodule

`default_nettype wire

// File: hw/rtl/integer_to_text_formatter_core.sv
// top level of the integer to text formatter
// joins itf_ctrl and itf_datapath; uses itf_pkg
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   value .. precision, one number
//   out      output     out_valid_o / out_stall_i char_code, last_char, one character
//
// a number is loaded, then for decimal its 16, 32 or 64 bits are shifted through the bcd
// converter (no shifting for octal or hex); then come the conversion check, digit count,
// pad planning and segment select, then one character per cycle while the output does not
// stall, at most 64 characters.
// reset clears the controller, the conversion counter and the output valid; there is nothing to clear else.
// a stall on the output holds the character register and pauses the sequencer;
// the input is stalled from acceptance until the final character is issued.
`default_nettype none

module integer_to_text_formatter_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [itf_pkg::ValueW-1:0]    value_i,
  input  wire logic [1:0]                    size_mode_i,
  input  wire logic                          is_unsigned_i,
  input  wire logic [1:0]                    radix_select_i,
  input  wire logic                          alt_form_i,
  input  wire logic                          left_justify_i,
  input  wire logic                          zero_pad_i,
  input  wire logic [itf_pkg::WidthW-1:0]    width_i,
  input  wire logic [itf_pkg::PrecW-1:0]     precision_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         char_code_o,
  output logic                               last_char_o
);

  itf_pkg::cmd_t cmd;
  itf_pkg::sts_t sts;

  itf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .value_i        (value_i),
    .size_mode_i    (size_mode_i),
    .is_unsigned_i  (is_unsigned_i),
    .radix_select_i (radix_select_i),
    .alt_form_i     (alt_form_i),
    .left_justify_i (left_justify_i),
    .zero_pad_i     (zero_pad_i),
    .width_i        (width_i),
    .precision_i    (precision_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .char_code_o    (char_code_o),
    .last_char_o    (last_char_o)
  );

endmodule

`default_nettype wire
